// ===== hdl/bpw_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpw_pkg
// Shared types, constants and the binomial table for the point weight block.
// ---------------------------------------------------------------------------
package bpw_pkg;

    localparam int MAX_DEGREE_DEF = 15;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int DEG_W   = 4;
    localparam int DEG_MAX = (1 << DEG_W) - 1;
    localparam int BINOM_W = 13;
    localparam int BINOM_N = 1 << (2 * DEG_W);
    localparam int COORD_W = 32;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 32;

    typedef enum logic [CFG_IW-1:0] {
        REG_DEGREE      = 3'd0,
        REG_POINT_INDEX = 3'd1,
        REG_CTRL_X      = 3'd2,
        REG_CTRL_Y      = 3'd3,
        REG_CTRL_Z      = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [DEG_W-1:0]   n_eff;
        logic [DEG_W-1:0]   point_index;
        logic [BINOM_W-1:0] binom;
        logic [COORD_W-1:0] ctrl_x;
        logic [COORD_W-1:0] ctrl_y;
        logic [COORD_W-1:0] ctrl_z;
    } t_cfg_bus;

    typedef logic [BINOM_W-1:0] t_binom_lut [BINOM_N];

    // Pascal's triangle, entry {n, i}; zero where i > n
    function automatic t_binom_lut build_binom();
        t_binom_lut lut;
        int n;
        int i;
        for (n = 0; n <= DEG_MAX; n++) begin
            for (i = 0; i <= DEG_MAX; i++) begin
                if (i == 0) begin
                    lut[n * (DEG_MAX + 1) + i] = BINOM_W'(1);
                end else if (i > n) begin
                    lut[n * (DEG_MAX + 1) + i] = '0;
                end else begin
                    lut[n * (DEG_MAX + 1) + i] = lut[(n - 1) * (DEG_MAX + 1) + i - 1]
                                               + lut[(n - 1) * (DEG_MAX + 1) + i];
                end
            end
        end
        return lut;
    endfunction

    localparam t_binom_lut BINOM_LUT = build_binom();

endpackage

// ===== hdl/bpw_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpw_in_if
// Curve parameter channel: valid/ready with one t value per transaction.
// ---------------------------------------------------------------------------
interface bpw_in_if
    import bpw_pkg::*;
#(
    parameter int TW = FRAC_BITS_DEF + 1
) ();
    logic          valid;
    logic          ready;
    logic [TW-1:0] t_param;

    modport source (output valid, output t_param, input ready);
    modport sink   (input valid, input t_param, output ready);
endinterface

// ===== hdl/bpw_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpw_out_if
// Result channel: weight and the three weighted coordinates.
// ---------------------------------------------------------------------------
interface bpw_out_if
    import bpw_pkg::*;
#(
    parameter int TW = FRAC_BITS_DEF + 1
) ();
    logic               valid;
    logic               ready;
    logic [TW-1:0]      weight;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_z;

    modport source (output valid, output weight, output out_x, output out_y, output out_z,
                    input ready);
    modport sink   (input valid, input weight, input out_x, input out_y, input out_z,
                    output ready);
endinterface

// ===== hdl/bpw_cfg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpw_cfg
// Configuration registers, degree clamp and binomial coefficient register.
// ---------------------------------------------------------------------------
module bpw_cfg
    import bpw_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_cfg_bus          o_cfg
);
    localparam int N_CAP = (MAX_DEGREE < DEG_MAX) ? MAX_DEGREE : DEG_MAX;
    localparam logic [DEG_W-1:0] CAP = DEG_W'(N_CAP);

    logic [DEG_W-1:0]   r_degree, n_degree;
    logic [DEG_W-1:0]   r_point_index, n_point_index;
    logic [COORD_W-1:0] r_ctrl_x, n_ctrl_x;
    logic [COORD_W-1:0] r_ctrl_y, n_ctrl_y;
    logic [COORD_W-1:0] r_ctrl_z, n_ctrl_z;
    logic [BINOM_W-1:0] r_binom, n_binom;
    logic [DEG_W-1:0]   w_n_eff, w_n_eff_next;

    always_comb begin
        n_degree      = r_degree;
        n_point_index = r_point_index;
        n_ctrl_x      = r_ctrl_x;
        n_ctrl_y      = r_ctrl_y;
        n_ctrl_z      = r_ctrl_z;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEGREE:      n_degree      = i_cfg_data[DEG_W-1:0];
                REG_POINT_INDEX: n_point_index = i_cfg_data[DEG_W-1:0];
                REG_CTRL_X:      n_ctrl_x      = i_cfg_data[COORD_W-1:0];
                REG_CTRL_Y:      n_ctrl_y      = i_cfg_data[COORD_W-1:0];
                REG_CTRL_Z:      n_ctrl_z      = i_cfg_data[COORD_W-1:0];
                default:         ;
            endcase
        end
        w_n_eff_next = (n_degree > CAP) ? CAP : n_degree;
        // table already holds zero for an index above the degree
        n_binom      = BINOM_LUT[{w_n_eff_next, n_point_index}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree      <= DEG_W'(3);
            r_point_index <= '0;
            r_ctrl_x      <= '0;
            r_ctrl_y      <= '0;
            r_ctrl_z      <= '0;
            r_binom       <= BINOM_W'(1);
        end else begin
            r_degree      <= n_degree;
            r_point_index <= n_point_index;
            r_ctrl_x      <= n_ctrl_x;
            r_ctrl_y      <= n_ctrl_y;
            r_ctrl_z      <= n_ctrl_z;
            r_binom       <= n_binom;
        end
    end

    assign w_n_eff = (r_degree > CAP) ? CAP : r_degree;

    assign o_cfg.n_eff       = w_n_eff;
    assign o_cfg.point_index = r_point_index;
    assign o_cfg.binom       = r_binom;
    assign o_cfg.ctrl_x      = r_ctrl_x;
    assign o_cfg.ctrl_y      = r_ctrl_y;
    assign o_cfg.ctrl_z      = r_ctrl_z;

    a_binom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_binom == '0) == (r_point_index > w_n_eff))
        else $error("binomial coefficient out of step with degree and index");

endmodule

// ===== hdl/bpw_power.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpw_power
// Power product (1-t)^(n-i) * t^i: an input clamp register, then one rounded multiply per later pipeline stage.
// ---------------------------------------------------------------------------
module bpw_power
    import bpw_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [FRAC_BITS:0] i_t_param,
    input  t_cfg_bus           i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FRAC_BITS:0] o_power
);
    localparam int TW = FRAC_BITS + 1;
    localparam int NS = (MAX_DEGREE < DEG_MAX) ? MAX_DEGREE : DEG_MAX;
    localparam int MW = 2 * TW;
    localparam logic [TW-1:0] ONE  = TW'(1) << FRAC_BITS;
    localparam logic [MW-1:0] HALF = MW'(1) << (FRAC_BITS - 1);

    logic [NS:0]   r_v;
    logic [NS:0]   w_en;
    logic [TW-1:0] r_t [NS];
    logic [TW-1:0] r_u [NS];
    logic [TW-1:0] r_p [NS+1];
    logic [TW-1:0] w_p_next [NS];
    logic [TW-1:0] w_t_clamp;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_en[NS] = !r_v[NS] || i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_t_clamp = (i_t_param > ONE) ? ONE : i_t_param;

    for (genvar k = 1; k <= NS; k++) begin : g_stage
        localparam logic [DEG_W:0] STEP = (DEG_W + 1)'(k - 1);

        logic [DEG_W:0] w_sum;
        logic           w_use_u;
        logic           w_use_t;
        logic [TW-1:0]  w_f;
        logic [MW-1:0]  w_prod;

        // steps below n-i take (1-t), steps below n take t, the rest pass
        assign w_sum   = STEP + {1'b0, i_cfg.point_index};
        assign w_use_u = w_sum < {1'b0, i_cfg.n_eff};
        assign w_use_t = STEP < {1'b0, i_cfg.n_eff};
        assign w_f     = w_use_u ? r_u[k-1] : (w_use_t ? r_t[k-1] : ONE);
        assign w_prod  = {{TW{1'b0}}, r_p[k-1]} * {{TW{1'b0}}, w_f} + HALF;

        assign w_p_next[k-1] = w_prod[FRAC_BITS +: TW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_t[0] <= w_t_clamp;
            r_u[0] <= ONE - w_t_clamp;
            r_p[0] <= ONE;
        end
        // t and 1-t are not needed past the last multiply
        for (int k = 1; k < NS; k++) begin
            if (w_en[k]) begin
                r_t[k] <= r_t[k-1];
                r_u[k] <= r_u[k-1];
            end
        end
        for (int k = 1; k <= NS; k++) begin
            if (w_en[k]) begin
                r_p[k] <= w_p_next[k-1];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS];
    assign o_power = r_p[NS];

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS] |-> (r_p[NS] <= ONE))
        else $error("power product above one");

endmodule

// ===== hdl/bpw_scale.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpw_scale
// Weight stage (binomial times power, saturated) and coordinate scaling
// stage, whose registers are the output register.
// ---------------------------------------------------------------------------
module bpw_scale
    import bpw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [FRAC_BITS:0] i_power,
    input  t_cfg_bus           i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [FRAC_BITS:0] o_weight,
    output logic [COORD_W-1:0] o_x,
    output logic [COORD_W-1:0] o_y,
    output logic [COORD_W-1:0] o_z
);
    localparam int TW  = FRAC_BITS + 1;
    localparam int WPW = BINOM_W + TW;
    localparam int PW  = COORD_W + TW + 1;
    localparam logic [TW-1:0] ONE    = TW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);

    // round(c * w / ONE), ties toward plus infinity
    function automatic logic [COORD_W-1:0] scale_coord(logic [COORD_W-1:0] c,
                                                       logic [TW-1:0] w);
        logic signed [PW-1:0] prod;
        prod = $signed({{(PW - COORD_W){c[COORD_W-1]}}, c})
             * $signed({{(PW - TW){1'b0}}, w})
             + $signed(HALF_P);
        return prod[FRAC_BITS +: COORD_W];
    endfunction

    logic               r_va, r_vb;
    logic               w_en_a, w_en_b;
    logic [TW-1:0]      r_w, r_wb;
    logic [COORD_W-1:0] r_x, r_y, r_z;
    logic [WPW-1:0]     w_wprod;
    logic [TW-1:0]      w_wsat;

    assign w_en_b  = !r_vb || i_ready;
    assign w_en_a  = !r_va || w_en_b;
    assign w_wprod = {{TW{1'b0}}, i_cfg.binom} * {{BINOM_W{1'b0}}, i_power};
    assign w_wsat  = (w_wprod > WPW'(ONE)) ? ONE : w_wprod[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_va <= i_valid;
            end
            if (w_en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_w <= w_wsat;
        end
        if (w_en_b) begin
            r_wb <= r_w;
            r_x  <= scale_coord(i_cfg.ctrl_x, r_w);
            r_y  <= scale_coord(i_cfg.ctrl_y, r_w);
            r_z  <= scale_coord(i_cfg.ctrl_z, r_w);
        end
    end

    assign o_ready  = w_en_a;
    assign o_valid  = r_vb;
    assign o_weight = r_wb;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_z      = r_z;

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va |-> (r_w <= ONE))
        else $error("weight above one");

    a_zero_binom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_va && (i_cfg.binom == '0)) |-> (r_w == '0))
        else $error("nonzero weight with zero binomial coefficient");

    a_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb && (r_wb == '0)) |-> ((r_x == '0) && (r_y == '0) && (r_z == '0)))
        else $error("nonzero coordinate with zero weight");

endmodule

// ===== hdl/bernstein_point_weight.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bernstein_point_weight
// Scales one Bezier control point by its Bernstein weight C(n,i)(1-t)^(n-i)t^i.
//
//   channel  dir  handshake      payload
//   i_in     in   valid/ready    t_param (unsigned Q1.FRAC_BITS)
//   o_out    out  valid/ready    weight Q1.FRAC_BITS; out_x/y/z Q16.16
//   cfg      in   write enable   i_cfg_idx, i_cfg_data
//
// One transaction per cycle sustained while o_out is ready; the stages are:
// clamp stage, one rounded 17x17 multiply stage per power step,
// weight stage, then the coordinate multipliers feeding the output register.
// Reset is synchronous and empties the pipeline; config returns to degree 3.
// Each stage advances when empty or when the next advances, so an output
// stall fills bubbles before input ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module bernstein_point_weight
    import bpw_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    bpw_in_if.sink            i_in,
    bpw_out_if.source         o_out
);
    t_cfg_bus           w_cfg;
    logic               w_pw_valid;
    logic               w_pw_ready;
    logic [FRAC_BITS:0] w_power;

    bpw_cfg #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bpw_power #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_power (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_t_param (i_in.t_param),
        .i_cfg     (w_cfg),
        .o_valid   (w_pw_valid),
        .i_ready   (w_pw_ready),
        .o_power   (w_power)
    );

    bpw_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pw_valid),
        .o_ready  (w_pw_ready),
        .i_power  (w_power),
        .i_cfg    (w_cfg),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_weight (o_out.weight),
        .o_x      (o_out.out_x),
        .o_y      (o_out.out_y),
        .o_z      (o_out.out_z)
    );

endmodule
